@@ hw/rtl/mbrx_pkg.sv @@
// shared types, codes and crc helper for the modbus rtu receiver
package mbrx_pkg;

  // field widths fixed by the frame format
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned CRC_W   = 16;
  localparam int unsigned IDLE_W  = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CRC_W-1:0]   CRC_START      = 16'hFFFF;
  localparam logic [CRC_W-1:0]   CRC_POLY       = 16'hA001;
  localparam logic [BYTE_W-1:0]  BROADCAST_ADDR = 8'h00;
  localparam logic [IDLE_W-1:0]  IDLE_MAX       = 16'hFFFF;
  localparam logic [COUNT_W-1:0] MIN_FRAME_LEN  = 9'd3;

  // reset values of the configuration registers
  localparam logic [BYTE_W-1:0] SLAVE_ADDR_RESET = 8'd1;
  localparam logic [IDLE_W-1:0] TIMEOUT_RESET    = 16'd35;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLAVE_ADDRESS = 2'd0,
    REG_TIMEOUT_TICKS = 2'd1
  } cfg_reg_t;

  // request operation codes
  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  // result kinds
  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_TIMEOUT = 2'd2
  } kind_t;

  typedef struct packed {
    op_t               operation;
    logic [BYTE_W-1:0] rx_byte;
  } rx_item_t;

  typedef struct packed {
    kind_t              kind;
    logic [BYTE_W-1:0]  data_byte;
    logic [BYTE_W-1:0]  position;
    logic [COUNT_W-1:0] frame_length;
  } rx_result_t;

  // one byte through the reflected modbus crc-16
  function automatic logic [CRC_W-1:0] crc_advance(input logic [CRC_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/modbus_rtu_frame_receiver.sv @@
// modbus rtu receive deframer: address filter, byte positions, crc check, idle timeout
// a result appears in the output register in the cycle after its request is taken
// throughput: one byte or tick request per cycle while in_ready; crc and frame counters
// are combinational, and the output register frees itself when its result is taken
// reset (synchronous, active high): frame state cleared, crc at 0xFFFF, slave address 1,
// timeout 35 ticks, output register empty
module modbus_rtu_frame_receiver #(
  parameter int unsigned FRAME_MAX = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  mbrx_pkg::rx_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output mbrx_pkg::rx_result_t              out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mbrx_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mbrx_pkg::IDLE_W-1:0]       cfg_data
);
  import mbrx_pkg::*;

  localparam logic [COUNT_W-1:0] FrameMaxW = COUNT_W'(FRAME_MAX);

  // configuration
  logic [BYTE_W-1:0] slave_address;
  logic [IDLE_W-1:0] timeout_ticks;

  // frame state
  logic [COUNT_W-1:0] byte_count, byte_count_next;
  logic [BYTE_W-1:0]  dest_address, dest_address_next;
  logic [CRC_W-1:0]   crc_remainder, crc_remainder_next;
  logic [IDLE_W-1:0]  idle_count, idle_count_next;

  // result produced by the current request
  logic       res_valid;
  rx_result_t res;

  logic              in_take;
  logic [BYTE_W-1:0] dest_sel;
  logic              addr_ok;
  logic [CRC_W-1:0]  crc_new;
  logic [COUNT_W-1:0] count_inc;
  logic [IDLE_W-1:0] idle_inc;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_take   = in_valid && in_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= SLAVE_ADDR_RESET;
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SLAVE_ADDRESS: slave_address <= cfg_data[BYTE_W-1:0];
        REG_TIMEOUT_TICKS: timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // byte and tick datapath
  always_comb begin
    dest_sel  = (byte_count == '0) ? in_data.rx_byte : dest_address;
    addr_ok   = (dest_sel == slave_address) || (dest_sel == BROADCAST_ADDR);
    crc_new   = crc_advance(crc_remainder, in_data.rx_byte);
    count_inc = byte_count + COUNT_W'(1);
    idle_inc  = (idle_count == IDLE_MAX) ? idle_count : idle_count + IDLE_W'(1);

    byte_count_next    = byte_count;
    dest_address_next  = dest_address;
    crc_remainder_next = crc_remainder;
    idle_count_next    = idle_count;
    res_valid          = 1'b0;
    res.kind           = KIND_BYTE;
    res.data_byte      = in_data.rx_byte;
    res.position       = byte_count[BYTE_W-1:0];
    res.frame_length   = count_inc;

    if (in_take) begin
      if (in_data.operation == OP_BYTE) begin
        dest_address_next = dest_sel;
        if (addr_ok && (byte_count < FrameMaxW)) begin
          res_valid = 1'b1;
          if ((crc_new == '0) && (count_inc > MIN_FRAME_LEN)) begin
            res.kind           = KIND_DONE;
            byte_count_next    = '0;
            crc_remainder_next = CRC_START;
            idle_count_next    = '0;
          end else begin
            byte_count_next    = count_inc;
            crc_remainder_next = crc_new;
            idle_count_next    = '0;
          end
        end
      end else if (byte_count != '0) begin
        if (idle_inc >= timeout_ticks) begin
          res_valid          = 1'b1;
          res.kind           = KIND_TIMEOUT;
          res.data_byte      = '0;
          res.position       = '0;
          res.frame_length   = byte_count;
          byte_count_next    = '0;
          crc_remainder_next = CRC_START;
          idle_count_next    = '0;
        end else begin
          idle_count_next = idle_inc;
        end
      end
    end
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      dest_address  <= '0;
      crc_remainder <= CRC_START;
      idle_count    <= '0;
    end else begin
      byte_count    <= byte_count_next;
      dest_address  <= dest_address_next;
      crc_remainder <= crc_remainder_next;
      idle_count    <= idle_count_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && res_valid) begin
      out_data <= res;
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
// testbench for the modbus rtu receive deframer: predicted frame events checked per request
`timescale 1ns / 1ps

module tb_top;
  import mbrx_pkg::*;

  localparam int FRAME_MAX = 256;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_FLUSH_TICKS = 12;
  // indexes past the register list, expected to be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  rx_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rx_result_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [IDLE_W-1:0] cfg_data = '0;

  modbus_rtu_frame_receiver #(.FRAME_MAX(FRAME_MAX)) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // requests waiting to be offered and frame events still owed by the block
  rx_item_t rx_requests_q[$];
  rx_result_t frame_events_due[$];
  logic [BYTE_W-1:0] frame_body[$];

  int error_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_req = 1'b0;
  int stall_hold_left = 0;

  // shadow of the configuration registers
  logic [BYTE_W-1:0] slave_cfg = SLAVE_ADDR_RESET;
  logic [IDLE_W-1:0] timeout_cfg = TIMEOUT_RESET;

  // shadow of the frame state
  logic [COUNT_W-1:0] rx_count = '0;
  logic [BYTE_W-1:0] rx_dest = '0;
  logic [CRC_W-1:0] rx_crc = CRC_START;
  logic [IDLE_W-1:0] rx_idle = '0;

  rx_result_t drv_event;
  rx_result_t mon_event;

  // reflected crc-16, one byte, lsb first
  function automatic logic [CRC_W-1:0] modbus_crc_byte(input logic [CRC_W-1:0] crc,
                                                       input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] r;
    r = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
    end
    return r;
  endfunction

  function automatic void clear_frame_state();
    rx_count = '0;
    rx_crc = CRC_START;
    rx_idle = '0;
  endfunction

  // advance the frame state by one request; returns 1 when an event comes out
  function automatic bit deframe_item(input rx_item_t it, output rx_result_t ev);
    ev = '0;
    if (it.operation == OP_BYTE) begin
      if (rx_count == 0) rx_dest = it.rx_byte;
      if (!(rx_dest == slave_cfg || rx_dest == BROADCAST_ADDR) || rx_count >= FRAME_MAX)
        return 1'b0;
      ev.kind = KIND_BYTE;
      ev.data_byte = it.rx_byte;
      ev.position = rx_count[BYTE_W-1:0];
      rx_idle = '0;
      rx_crc = modbus_crc_byte(rx_crc, it.rx_byte);
      rx_count = rx_count + 1'b1;
      ev.frame_length = rx_count;
      if (rx_crc == 0 && rx_count > 3) begin
        ev.kind = KIND_DONE;
        clear_frame_state();
      end
      return 1'b1;
    end
    // timer tick
    if (rx_count == 0) return 1'b0;
    if (rx_idle != IDLE_MAX) rx_idle = rx_idle + 1'b1;
    if (rx_idle >= timeout_cfg) begin
      ev.kind = KIND_TIMEOUT;
      ev.frame_length = rx_count;
      clear_frame_state();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // driver: offer queued requests, predict on acceptance
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (deframe_item(in_data, drv_event)) frame_events_due.push_back(drv_event);
      end
      if (!in_valid || in_ready) begin
        if (rx_requests_q.size() != 0 &&
            !(send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)) begin
          in_valid <= 1'b1;
          in_data <= rx_requests_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (rst) begin
      stall_hold_left <= 0;
    end else if (hold_req) begin
      stall_hold_left <= HOLD_CYCLES;
    end else if (stall_hold_left != 0) begin
      stall_hold_left <= stall_hold_left - 1;
    end
  end

  // monitor: take results and compare against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (frame_events_due.size() == 0) begin
          $error("unexpected result: kind %0d data_byte %0h position %0d frame_length %0d",
                 out_data.kind, out_data.data_byte, out_data.position, out_data.frame_length);
          error_count++;
        end else begin
          mon_event = frame_events_due.pop_front();
          if (out_data.kind !== mon_event.kind) begin
            $error("kind: expected %0d, actual %0d", mon_event.kind, out_data.kind);
            error_count++;
          end
          if (out_data.data_byte !== mon_event.data_byte) begin
            $error("data_byte: expected %0h, actual %0h", mon_event.data_byte,
                   out_data.data_byte);
            error_count++;
          end
          if (out_data.position !== mon_event.position) begin
            $error("position: expected %0d, actual %0d", mon_event.position, out_data.position);
            error_count++;
          end
          if (out_data.frame_length !== mon_event.frame_length) begin
            $error("frame_length: expected %0d, actual %0d", mon_event.frame_length,
                   out_data.frame_length);
            error_count++;
          end
        end
      end
      out_ready <= (stall_hold_left == 0) &&
                   !(recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // register write over the config channel, shadow updated on acceptance
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [IDLE_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    if (idx == REG_SLAVE_ADDRESS) slave_cfg = val[BYTE_W-1:0];
    else if (idx == REG_TIMEOUT_TICKS) timeout_cfg = val;
    @(negedge clk);
  endtask

  // all requests taken and all events seen, then a settling wait for the output stage
  task automatic wait_drained();
    while (rx_requests_q.size() != 0 || in_valid || frame_events_due.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic push_byte(input logic [BYTE_W-1:0] b);
    rx_item_t it;
    it.operation = OP_BYTE;
    it.rx_byte = b;
    rx_requests_q.push_back(it);
  endtask

  task automatic push_ticks(input int n);
    rx_item_t it;
    it.operation = OP_TICK;
    repeat (n) begin
      it.rx_byte = 8'($urandom_range(0, 255));
      rx_requests_q.push_back(it);
    end
  endtask

  task automatic fill_body(input int n);
    frame_body.delete();
    repeat (n) frame_body.push_back(8'($urandom_range(0, 255)));
  endtask

  // address, body, crc low then high; a broken frame gets a bad or truncated crc
  task automatic push_frame(input logic [BYTE_W-1:0] addr, input bit good);
    logic [CRC_W-1:0] crc;
    crc = modbus_crc_byte(CRC_START, addr);
    push_byte(addr);
    foreach (frame_body[i]) begin
      push_byte(frame_body[i]);
      crc = modbus_crc_byte(crc, frame_body[i]);
    end
    if (!good) crc = crc ^ 16'($urandom_range(1, 65535));
    push_byte(crc[7:0]);
    if (good || $urandom_range(0, 1) == 0) push_byte(crc[15:8]);
  endtask

  task automatic start_phase(input logic [BYTE_W-1:0] addr, input logic [IDLE_W-1:0] ticks,
                             input int send_pct, input int recv_pct);
    wait_drained();
    write_reg(REG_SLAVE_ADDRESS, {8'h00, addr});
    write_reg(REG_TIMEOUT_TICKS, ticks);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // mostly well-formed frames; with noise also broken, foreign and stray requests
  task automatic gen_traffic(input int n, input bit noise);
    int pick;
    int flush;
    logic [BYTE_W-1:0] addr;
    rx_item_t it;
    flush = (timeout_cfg == 0) ? 1 :
            ((timeout_cfg > MAX_FLUSH_TICKS) ? MAX_FLUSH_TICKS : int'(timeout_cfg));
    while (rx_requests_q.size() < n) begin
      pick = $urandom_range(0, 99);
      addr = ($urandom_range(0, 3) == 0) ? BROADCAST_ADDR : slave_cfg;
      if (!noise || pick < 60) begin
        fill_body(($urandom_range(0, 7) == 0) ? $urandom_range(0, 24) : $urandom_range(0, 6));
        push_frame(addr, 1'b1);
        push_ticks($urandom_range(0, 2));
      end else if (pick < 75) begin
        fill_body($urandom_range(0, 6));
        push_frame(addr, 1'b0);
        push_ticks(flush);
      end else if (pick < 85) begin
        fill_body($urandom_range(0, 4));
        push_frame(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        push_ticks(flush);
      end else begin
        it.operation = op_t'($urandom_range(0, 1));
        it.rx_byte = 8'($urandom_range(0, 255));
        rx_requests_q.push_back(it);
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset config: tick with no frame, foreign byte, addressed and broadcast frames
    push_ticks(1);
    push_byte(8'h05);
    frame_body = '{8'h03, 8'h00, 8'h00, 8'h00, 8'h01};
    push_frame(8'h01, 1'b1);
    frame_body = '{8'hFF};
    push_frame(BROADCAST_ADDR, 1'b1);

    // timeout of zero acts as one tick
    wait_drained();
    write_reg(REG_TIMEOUT_TICKS, 16'd0);
    push_byte(8'h01);
    push_byte(8'hAA);
    push_ticks(1);

    // address rewritten while a frame is open: later bytes dropped until timeout
    wait_drained();
    write_reg(REG_SLAVE_ADDRESS, 16'h00FF);
    write_reg(REG_TIMEOUT_TICKS, 16'd2);
    write_reg(REG_SPARE_2, 16'($urandom_range(0, 65535)));
    write_reg(REG_SPARE_3, 16'hFFFF);
    push_byte(8'hFF);
    push_byte(8'h12);
    wait_drained();
    write_reg(REG_SLAVE_ADDRESS, 16'h0000);
    push_byte(8'h34);
    push_ticks(2);

    // frame full: bytes past the limit dropped and do not reset the idle count
    start_phase(8'h80, 16'd3, 0, 0);
    fill_body(FRAME_MAX + 3);
    push_byte(8'h80);
    foreach (frame_body[i]) push_byte(frame_body[i]);
    push_ticks(1);
    push_byte(8'h55);
    push_ticks(2);

    // random traffic across idling patterns and settings
    start_phase(8'h01, 16'd4, 0, 0);
    gen_traffic(160, 1'b1);
    start_phase(8'hFF, 16'd1, 81, 0);
    gen_traffic(150, 1'b1);
    start_phase(8'h00, 16'hFFFF, 0, 81);
    gen_traffic(150, 1'b0);
    start_phase(8'h5A, 16'd6, 24, 24);
    gen_traffic(150, 1'b1);

    // receiver holds off while requests keep coming, so the input stalls
    start_phase(8'hA5, 16'd0, 0, 0);
    gen_traffic(150, 1'b1);
    @(posedge clk);
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;

    start_phase(8'($urandom_range(0, 255)), 16'($urandom_range(1, 10)), 24, 24);
    gen_traffic(140, 1'b1);

    wait_drained();
    repeat (10) @(negedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
